// File: rtl/rrpm_pkg.sv
// shared types and constants of the round robin poll master
// no dependencies; used by rrpm_core and round_robin_poll_master
package rrpm_pkg;

  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned TMO_W    = 16;
  localparam int unsigned RETRY_W  = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned BUSY_W   = 4;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned PORT_CH_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SLOT_W-1:0]  RESET_SLOT_MS    = 16'd100;
  localparam logic [TMO_W-1:0]   RESET_TIMEOUT_MS = 16'd100;
  localparam logic [RETRY_W-1:0] RESET_RETRIES    = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_SLOT     = 2'd0,
    CFG_REPLY_TIMEOUT = 2'd1,
    CFG_RETRY_LIMIT   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_VALID     = 2'd1,
    ACT_INVALID   = 2'd2,
    ACT_LINK_ERR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    RSN_NONE        = 3'd0,
    RSN_TIMEOUT     = 3'd1,
    RSN_BAD_REPLY   = 3'd2,
    RSN_LINK        = 3'd3,
    RSN_RETRY_LIMIT = 3'd4
  } reason_e;

  typedef struct packed {
    reason_e              reason;
    logic [PORT_CH_W-1:0] chan;
    logic [RETRY_W-1:0]   retry;
    logic [CODE_W-1:0]    detail;
  } err_log_t;

  // result flags, send_request in the lowest bit when packed into tuser
  typedef struct packed {
    logic skipped;
    logic completed;
    logic gave_up;
    logic send;
  } flags_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [TMO_W-1:0]   timeout;
    logic [RETRY_W-1:0] limit;
  } cfg_t;

endpackage

// File: rtl/rrpm_core.sv
// next-state and result logic for one event of the poll master
// depends on rrpm_pkg
module rrpm_core #(
  parameter int unsigned NUM_CHANNELS = 4,
  localparam int unsigned CW = (NUM_CHANNELS > 4) ? 3 : 2
) (
  input  rrpm_pkg::cfg_t                    cfg_i,
  input  rrpm_pkg::action_e                 action_i,
  input  logic [rrpm_pkg::PORT_CH_W-1:0]    channel_i,
  input  logic [rrpm_pkg::TIME_W-1:0]       now_i,
  input  logic [rrpm_pkg::BUSY_W-1:0]       busy_i,
  input  logic [rrpm_pkg::CODE_W-1:0]       code_i,
  input  logic                              awaiting_i,
  input  logic [CW-1:0]                     active_i,
  input  logic [CW-1:0]                     next_i,
  input  logic [rrpm_pkg::RETRY_W-1:0]      retries_i,
  input  logic [rrpm_pkg::TIME_W-1:0]       req_time_i,
  input  logic [rrpm_pkg::TIME_W-1:0]       next_poll_i,
  input  rrpm_pkg::err_log_t                log_i,
  output logic                              awaiting_o,
  output logic [CW-1:0]                     active_o,
  output logic [CW-1:0]                     next_o,
  output logic [rrpm_pkg::RETRY_W-1:0]      retries_o,
  output logic [rrpm_pkg::TIME_W-1:0]       req_time_o,
  output logic [rrpm_pkg::TIME_W-1:0]       next_poll_o,
  output rrpm_pkg::err_log_t                log_o,
  output rrpm_pkg::flags_t                  flags_o,
  output logic [rrpm_pkg::PORT_CH_W-1:0]    out_chan_o
);

  logic [rrpm_pkg::TIME_W-1:0] elapsed;
  logic [rrpm_pkg::TIME_W-1:0] since_poll;
  logic [CW-1:0]               ch_ext;
  logic                        ch_ok;
  logic                        ch_match;
  logic                        fail;
  rrpm_pkg::reason_e           fail_reason;
  logic [rrpm_pkg::CODE_W-1:0] fail_detail;
  logic                        start;
  logic [CW-1:0]               ev_ch;
  logic                        busy_hit;
  logic                        finish;
  logic                        fin_now_based;
  logic [rrpm_pkg::TIME_W-1:0] fin_elapsed;
  logic [rrpm_pkg::TIME_W-1:0] fin_base;

  assign elapsed    = now_i - req_time_i;
  assign since_poll = now_i - next_poll_i;
  assign ch_ext     = CW'(channel_i);
  assign ch_ok      = 32'(channel_i) < NUM_CHANNELS;
  assign ch_match   = ch_ok && awaiting_i && (ch_ext == active_i);
  // channels above the busy mask width are never busy
  assign busy_hit   = (32'(ev_ch) < rrpm_pkg::BUSY_W) &&
                      busy_i[ev_ch[rrpm_pkg::PORT_CH_W-1:0]];

  always_comb begin
    awaiting_o    = awaiting_i;
    active_o      = active_i;
    next_o        = next_i;
    retries_o     = retries_i;
    req_time_o    = req_time_i;
    next_poll_o   = next_poll_i;
    log_o         = log_i;
    flags_o       = '0;
    out_chan_o    = '0;
    fail          = 1'b0;
    fail_reason   = rrpm_pkg::RSN_NONE;
    fail_detail   = '0;
    start         = 1'b0;
    ev_ch         = active_i;
    finish        = 1'b0;
    fin_now_based = 1'b0;

    // event decode
    unique case (action_i)
      rrpm_pkg::ACT_TICK: begin
        if (awaiting_i) begin
          if (elapsed >= 32'(cfg_i.timeout)) begin
            fail        = 1'b1;
            fail_reason = rrpm_pkg::RSN_TIMEOUT;
          end
        end else if (!since_poll[rrpm_pkg::TIME_W-1]) begin
          start = 1'b1;
          ev_ch = next_i;
        end
      end
      rrpm_pkg::ACT_LINK_ERR: begin
        if (ch_ok) begin
          log_o.reason = rrpm_pkg::RSN_LINK;
          log_o.chan   = channel_i;
          log_o.retry  = retries_i;
          log_o.detail = code_i;
          if (ch_match) begin
            fail        = 1'b1;
            fail_reason = rrpm_pkg::RSN_LINK;
            fail_detail = code_i;
          end
        end
      end
      rrpm_pkg::ACT_VALID: begin
        if (ch_match) begin
          flags_o.completed = 1'b1;
          out_chan_o        = channel_i;
          finish            = 1'b1;
        end
      end
      rrpm_pkg::ACT_INVALID: begin
        if (ch_match) begin
          fail        = 1'b1;
          fail_reason = rrpm_pkg::RSN_BAD_REPLY;
        end
      end
      default: ;
    endcase

    // failed attempt: retry or give up
    if (fail) begin
      log_o.reason = fail_reason;
      log_o.chan   = ev_ch[rrpm_pkg::PORT_CH_W-1:0];
      log_o.retry  = retries_i;
      log_o.detail = fail_detail;
      if (retries_i < cfg_i.limit) begin
        retries_o = retries_i + 1'b1;
        start     = 1'b1;
      end else begin
        log_o.reason    = rrpm_pkg::RSN_RETRY_LIMIT;
        log_o.detail    = '0;
        flags_o.gave_up = 1'b1;
        out_chan_o      = ev_ch[rrpm_pkg::PORT_CH_W-1:0];
        finish          = 1'b1;
      end
    end

    // poll start, busy channels finish at once
    if (start) begin
      out_chan_o = ev_ch[rrpm_pkg::PORT_CH_W-1:0];
      req_time_o = now_i;
      if (busy_hit) begin
        flags_o.skipped = 1'b1;
        finish          = 1'b1;
        fin_now_based   = 1'b1;
      end else begin
        active_o     = ev_ch;
        awaiting_o   = 1'b1;
        flags_o.send = 1'b1;
      end
    end

    fin_elapsed = fin_now_based ? '0 : elapsed;
    fin_base    = fin_now_based ? now_i : req_time_i;
    if (finish) begin
      awaiting_o = 1'b0;
      retries_o  = '0;
      next_o     = (32'(ev_ch) == NUM_CHANNELS - 1) ? '0 : ev_ch + 1'b1;
      if (fin_elapsed < 32'(cfg_i.slot)) begin
        next_poll_o = fin_base + 32'(cfg_i.slot);
      end else begin
        next_poll_o = now_i;
      end
    end
  end

endmodule

// File: rtl/round_robin_poll_master.sv
// round robin poll master: an input transaction passes the input register, then
// the result register; throughput 1 event per cycle while the result stream accepts,
// set by the single pass of rrpm_core between the two registers
// reset: channel state, error log and configuration (slot 100, timeout 100,
// retry limit 3) clear asynchronously on rst_ni low; no clearing pass
// depends on rrpm_pkg and rrpm_core
module round_robin_poll_master #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel [1:0], now_ms [33:2], busy_mask [37:34], link_error_code [45:38], zero pad
  input  logic [47:0] s_axis_tdata,
  // action [1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_channel [1:0], error_reason [4:2], error_channel [6:5], error_retry [10:7],
  // error_detail [18:11], zero pad
  output logic [23:0] m_axis_tdata,
  // send_request [0], gave_up [1], completed [2], skipped [3]
  output logic [3:0]  m_axis_tuser
);

  localparam int unsigned CW = (NUM_CHANNELS > 4) ? 3 : 2;

  // configuration registers
  rrpm_pkg::cfg_t cfg_q;

  // input register
  logic        in_valid_q;
  logic [47:0] in_data_q;
  logic [1:0]  in_user_q;

  // channel state
  logic                           awaiting_q, awaiting_d;
  logic [CW-1:0]                  active_q, active_d;
  logic [CW-1:0]                  next_q, next_d;
  logic [rrpm_pkg::RETRY_W-1:0]   retries_q, retries_d;
  logic [rrpm_pkg::TIME_W-1:0]    req_time_q, req_time_d;
  logic [rrpm_pkg::TIME_W-1:0]    next_poll_q, next_poll_d;
  rrpm_pkg::err_log_t             log_q, log_d;

  // result register
  logic                           out_valid_q;
  rrpm_pkg::flags_t               out_flags_q, flags_d;
  logic [rrpm_pkg::PORT_CH_W-1:0] out_chan_q, out_chan_d;
  rrpm_pkg::err_log_t             out_log_q;

  logic out_free;
  logic advance;
  logic in_take;

  // result slot free when empty or being drained this cycle
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot    <= rrpm_pkg::RESET_SLOT_MS;
      cfg_q.timeout <= rrpm_pkg::RESET_TIMEOUT_MS;
      cfg_q.limit   <= rrpm_pkg::RESET_RETRIES;
    end else if (cfg_valid_i) begin
      unique case (rrpm_pkg::cfg_idx_e'(cfg_index_i))
        rrpm_pkg::CFG_POLL_SLOT:     cfg_q.slot    <= cfg_data_i;
        rrpm_pkg::CFG_REPLY_TIMEOUT: cfg_q.timeout <= cfg_data_i;
        rrpm_pkg::CFG_RETRY_LIMIT:   cfg_q.limit   <= cfg_data_i[rrpm_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
      in_user_q <= s_axis_tuser;
    end
  end

  // one event per cycle through the decision logic while the result register is free
  rrpm_core #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_core (
    .cfg_i       (cfg_q),
    .action_i    (rrpm_pkg::action_e'(in_user_q)),
    .channel_i   (in_data_q[1:0]),
    .now_i       (in_data_q[33:2]),
    .busy_i      (in_data_q[37:34]),
    .code_i      (in_data_q[45:38]),
    .awaiting_i  (awaiting_q),
    .active_i    (active_q),
    .next_i      (next_q),
    .retries_i   (retries_q),
    .req_time_i  (req_time_q),
    .next_poll_i (next_poll_q),
    .log_i       (log_q),
    .awaiting_o  (awaiting_d),
    .active_o    (active_d),
    .next_o      (next_d),
    .retries_o   (retries_d),
    .req_time_o  (req_time_d),
    .next_poll_o (next_poll_d),
    .log_o       (log_d),
    .flags_o     (flags_d),
    .out_chan_o  (out_chan_d)
  );

  // state commits only when the event moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b0;
      active_q    <= '0;
      next_q      <= '0;
      retries_q   <= '0;
      req_time_q  <= '0;
      next_poll_q <= '0;
      log_q       <= '{reason: rrpm_pkg::RSN_NONE, chan: '0, retry: '0, detail: '0};
    end else if (advance) begin
      awaiting_q  <= awaiting_d;
      active_q    <= active_d;
      next_q      <= next_d;
      retries_q   <= retries_d;
      req_time_q  <= req_time_d;
      next_poll_q <= next_poll_d;
      log_q       <= log_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_flags_q <= flags_d;
      out_chan_q  <= out_chan_d;
      out_log_q   <= log_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_flags_q;
  assign m_axis_tdata  = {5'd0, out_log_q.detail, out_log_q.retry, out_log_q.chan,
                          out_log_q.reason, out_chan_q};

  // at most one flag per result
  a_flags_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tuser))
    else $error("more than one result flag set");

  // a give-up always leaves the retry limit entry in the log
  a_gave_up_logged : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_flags_q.gave_up) |-> (out_log_q.reason == rrpm_pkg::RSN_RETRY_LIMIT))
    else $error("give-up without retry limit entry");

  // a sent request leaves a reply outstanding
  a_send_awaits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && flags_d.send) |=> awaiting_q)
    else $error("request sent but no reply awaited");

  // retries only count while a reply is outstanding
  a_idle_no_retries : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !awaiting_q |-> (retries_q == '0))
    else $error("retry count held while idle");

  // state moves only with an event
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(awaiting_q) && $stable(next_poll_q) && $stable(log_q)))
    else $error("channel state changed without an event");

endmodule
